// ===== hdl/pcte_pkg.sv =====
// ----------------------------------------------------------------------------
// pcte_pkg
// Shared types and constants for the piecewise cubic evaluator.
// ----------------------------------------------------------------------------
package pcte_pkg;

   localparam int MAX_SEGMENTS_DEF = 16;
   localparam int MAX_JOINTS_DEF   = 8;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int SEG_CNT_W   = 5;
   localparam int JNT_CNT_W   = 4;
   localparam int SEG_IDX_W   = 4;
   localparam int JNT_IDX_W   = 3;
   localparam int VAL_W       = 32;
   localparam int TIME_W      = 31;

   // accumulator width: |a3|*d^3 < 2^124, plus shifted terms and sum headroom
   localparam int ACC_W       = 136;

   // 33-bit slices per wide product step
   localparam int MUL2_PARTS  = 2;
   localparam int MUL3_PARTS  = 3;

   // configuration register indexes
   localparam logic CSR_SEGMENTS = 1'b0;
   localparam logic CSR_JOINTS   = 1'b1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [SEG_IDX_W-1:0] segment_index;
      logic [JNT_IDX_W-1:0] joint_index;
      logic signed [31:0]   coef_const;
      logic signed [31:0]   coef_lin;
      logic signed [31:0]   coef_quad;
      logic signed [31:0]   coef_cubic;
      logic [TIME_W-1:0]    end_time;
      logic signed [31:0]   query_time;
   } req_type;

   typedef struct packed {
      logic [JNT_IDX_W-1:0] joint_number;
      logic signed [31:0]   position;
      logic signed [31:0]   velocity;
      logic                 status;
      logic                 last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEARCH_RD,
      ST_SEARCH,
      ST_COEF_RD,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SUM,
      ST_EMIT,
      ST_ERROR
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       do_load;
      logic       clamp;
      logic       seg_rd;
      logic       seg_check;
      logic       coef_rd;
      logic       mul1;
      logic       mul2;
      logic       mul3;
      logic [1:0] part;
      logic       sum;
      logic       emit;
      logic       error;
      logic       last;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic hit;
   } sts_type;

endpackage

// ===== hdl/pcte_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcte_ctrl
// Sequencer: load, segment search, per-joint multiply chain, emit and error.
// ----------------------------------------------------------------------------
module pcte_ctrl import pcte_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int MAX_JOINTS   = MAX_JOINTS_DEF,
   localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 mode,
   input  logic [SEG_CNT_W-1:0] seg_count,
   input  logic [JNT_CNT_W-1:0] jnt_count,
   input  sts_type              sts,
   output logic                 busy,
   output cmd_type              cmd,
   output logic [SW-1:0]        seg_sel,
   output logic [JW-1:0]        jnt_sel
);

   state_type state_ff, state_in;
   logic [SW:0]   seg_ff, seg_in;
   logic [JW:0]   jnt_ff, jnt_in;
   logic [SW:0]   nseg_ff, nseg_in;
   logic [JW:0]   njnt_ff, njnt_in;
   logic [1:0]    part_ff, part_in;
   logic [SEG_CNT_W:0] sc_w;
   logic [JNT_CNT_W:0] jc_w;

   // clamp register counts into the supported range
   always_comb begin
      sc_w = {1'b0, seg_count};
      jc_w = {1'b0, jnt_count};
      if (sc_w > (SEG_CNT_W+1)'(MAX_SEGMENTS)) begin
         nseg_in = (SW+1)'(MAX_SEGMENTS);
      end else begin
         nseg_in = (SW+1)'(sc_w);
      end
      if (jc_w == '0) begin
         njnt_in = (JW+1)'(1);
      end else if (jc_w > (JNT_CNT_W+1)'(MAX_JOINTS)) begin
         njnt_in = (JW+1)'(MAX_JOINTS);
      end else begin
         njnt_in = (JW+1)'(jc_w);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      jnt_in   = jnt_ff;
      part_in  = part_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               seg_in = '0;
               jnt_in = '0;
               if (mode == MODE_LOAD) begin
                  state_in = ST_LOAD;
               end else if (nseg_in == '0) begin
                  state_in = ST_ERROR;
               end else begin
                  state_in = ST_SEARCH_RD;
               end
            end
         end
         ST_LOAD:      state_in = ST_IDLE;
         ST_SEARCH_RD: state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (sts.hit) begin
               state_in = ST_COEF_RD;
            end else if (seg_ff + 1'b1 >= nseg_ff) begin
               state_in = ST_ERROR;
            end else begin
               seg_in   = seg_ff + 1'b1;
               state_in = ST_SEARCH_RD;
            end
         end
         ST_COEF_RD: state_in = ST_MUL1;
         ST_MUL1: begin
            part_in  = '0;
            state_in = ST_MUL2;
         end
         // two slices per second-level product
         ST_MUL2: begin
            if (part_ff == 2'(MUL2_PARTS - 1)) begin
               part_in  = '0;
               state_in = ST_MUL3;
            end else begin
               part_in = part_ff + 1'b1;
            end
         end
         // three slices for the cubic product
         ST_MUL3: begin
            if (part_ff == 2'(MUL3_PARTS - 1)) begin
               part_in  = '0;
               state_in = ST_SUM;
            end else begin
               part_in = part_ff + 1'b1;
            end
         end
         ST_SUM:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (jnt_ff + 1'b1 >= njnt_ff) begin
               state_in = ST_IDLE;
            end else begin
               jnt_in   = jnt_ff + 1'b1;
               state_in = ST_COEF_RD;
            end
         end
         ST_ERROR:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd           = '0;
      busy          = (state_ff != ST_IDLE);
      cmd.do_load   = (state_ff == ST_IDLE) && start && (mode == MODE_LOAD);
      cmd.clamp     = (state_ff == ST_IDLE) && start && (mode == MODE_QUERY);
      cmd.seg_rd    = (state_ff == ST_SEARCH_RD);
      cmd.seg_check = (state_ff == ST_SEARCH);
      cmd.coef_rd   = (state_ff == ST_COEF_RD);
      cmd.mul1      = (state_ff == ST_MUL1);
      cmd.mul2      = (state_ff == ST_MUL2);
      cmd.mul3      = (state_ff == ST_MUL3);
      cmd.part      = part_ff;
      cmd.sum       = (state_ff == ST_SUM);
      cmd.emit      = (state_ff == ST_EMIT);
      cmd.error     = (state_ff == ST_ERROR);
      cmd.last      = (jnt_ff + 1'b1 >= njnt_ff);
      seg_sel       = seg_ff[SW-1:0];
      jnt_sel       = jnt_ff[JW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seg_ff   <= '0;
         jnt_ff   <= '0;
         part_ff  <= '0;
         nseg_ff  <= '0;
         njnt_ff  <= (JW+1)'(1);
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         jnt_ff   <= jnt_in;
         part_ff  <= part_in;
         if (state_ff == ST_IDLE && start) begin
            nseg_ff <= nseg_in;
            njnt_ff <= njnt_in;
         end
      end
   end

endmodule

// ===== hdl/pcte_dp.sv =====
// ----------------------------------------------------------------------------
// pcte_dp
// Datapath: coefficient and end-time memories, clamp, compare, cubic terms,
// rounding and saturation.
// ----------------------------------------------------------------------------
module pcte_dp import pcte_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int MAX_JOINTS   = MAX_JOINTS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1,
   localparam int DEPTH = MAX_SEGMENTS * MAX_JOINTS,
   localparam int AW = SW + JW
) (
   input  logic                 clock,
   input  req_type              req,
   input  logic [SEG_CNT_W-1:0] seg_count,
   input  cmd_type              cmd,
   input  logic [SW-1:0]        seg_sel,
   input  logic [JW-1:0]        jnt_sel,
   output sts_type              sts,
   output logic                 rsp_valid,
   output rsp_type              rsp
);

   localparam int POS_SH = 3 * FRAC_BITS;
   localparam int VEL_SH = 2 * FRAC_BITS;

   // one row holds all four coefficients of a joint
   logic [4*VAL_W-1:0]  coef_mem [DEPTH];
   logic [TIME_W-1:0]   end_mem  [MAX_SEGMENTS];
   logic [4*VAL_W-1:0]  coef_rd_ff;
   logic [TIME_W-1:0]   end_rd_ff;
   logic [TIME_W-1:0]   prev_rd_ff;
   logic [TIME_W-1:0]   time_in;
   logic [TIME_W-1:0]   last_ff;
   logic [TIME_W-1:0]   d_ff;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic                ld_ok;
   logic [SW-1:0]       last_idx;
   logic [SEG_CNT_W:0]  last_w;

   // write address and guard for out-of-range loads
   always_comb begin
      ld_ok   = ({1'b0, req.segment_index} < (SEG_IDX_W+1)'(MAX_SEGMENTS)) &&
                ({1'b0, req.joint_index} < (JNT_IDX_W+1)'(MAX_JOINTS));
      wr_addr = {SW'(req.segment_index), JW'(req.joint_index)};
      rd_addr = {seg_sel, jnt_sel};
      if (seg_count > SEG_CNT_W'(MAX_SEGMENTS) || seg_count == '0) begin
         last_w = (SEG_CNT_W+1)'(MAX_SEGMENTS - 1);
      end else begin
         last_w = {1'b0, seg_count} - 1'b1;
      end
      last_idx = SW'(last_w);
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.do_load && ld_ok) begin
         coef_mem[wr_addr] <= {req.coef_const, req.coef_lin,
                               req.coef_quad, req.coef_cubic};
         end_mem[SW'(req.segment_index)] <= req.end_time;
      end
      if (cmd.clamp) begin
         last_ff <= end_mem[last_idx];
      end
      if (cmd.seg_rd) begin
         end_rd_ff  <= end_mem[seg_sel];
         prev_rd_ff <= (seg_sel == '0) ? '0 : end_mem[seg_sel - 1'b1];
      end
      if (cmd.coef_rd) begin
         coef_rd_ff <= coef_mem[rd_addr];
      end
   end

   // clamp query time: negative to zero, above the last end time to that end time
   logic qt_ff_neg;
   logic [TIME_W-1:0] qt_ff;
   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         qt_ff_neg <= req.query_time[31];
         qt_ff     <= req.query_time[TIME_W-1:0];
      end
   end

   always_comb begin
      if (qt_ff_neg) begin
         time_in = '0;
      end else if (qt_ff > last_ff) begin
         time_in = last_ff;
      end else begin
         time_in = qt_ff;
      end
   end

   always_comb begin
      sts.hit = (time_in >= prev_rd_ff) && (time_in <= end_rd_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.seg_check) begin
         d_ff <= time_in - prev_rd_ff;
      end
   end

   // multiply chain, every product at most one 33-bit slice by d per cycle
   logic signed [31:0]  a0, a1, a2, a3;
   logic signed [32:0]  ds;
   logic signed [65:0]  a1d_ff, a2d_ff, a3d_ff;
   logic signed [98:0]  a2d2_ff, a3d2_ff;
   logic signed [131:0] a3d3_ff;
   logic signed [ACC_W-1:0] pos_ff, vel_ff;
   logic signed [33:0]  m2a_op, m2b_op, m3_op;
   logic signed [66:0]  m2a_pr, m2b_pr, m3_pr;

   // slice select: low slices unsigned, top slice signed
   always_comb begin
      {a0, a1, a2, a3} = coef_rd_ff;
      ds = $signed({2'b00, d_ff});
      if (cmd.part == 2'd0) begin
         m2a_op = $signed({1'b0, a2d_ff[32:0]});
         m2b_op = $signed({1'b0, a3d_ff[32:0]});
      end else begin
         m2a_op = $signed({a2d_ff[65], a2d_ff[65:33]});
         m2b_op = $signed({a3d_ff[65], a3d_ff[65:33]});
      end
      unique case (cmd.part)
         2'd0:    m3_op = $signed({1'b0, a3d2_ff[32:0]});
         2'd1:    m3_op = $signed({1'b0, a3d2_ff[65:33]});
         default: m3_op = $signed({a3d2_ff[98], a3d2_ff[98:66]});
      endcase
      m2a_pr = m2a_op * ds;
      m2b_pr = m2b_op * ds;
      m3_pr  = m3_op * ds;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         a1d_ff <= 66'(a1 * ds);
         a2d_ff <= 66'(a2 * ds);
         a3d_ff <= 66'(a3 * ds);
      end
      if (cmd.mul2) begin
         if (cmd.part == 2'd0) begin
            a2d2_ff <= 99'(m2a_pr);
            a3d2_ff <= 99'(m2b_pr);
         end else begin
            a2d2_ff <= a2d2_ff + (99'(m2a_pr) <<< 33);
            a3d2_ff <= a3d2_ff + (99'(m2b_pr) <<< 33);
         end
      end
      if (cmd.mul3) begin
         unique case (cmd.part)
            2'd0:    a3d3_ff <= 132'(m3_pr);
            2'd1:    a3d3_ff <= a3d3_ff + (132'(m3_pr) <<< 33);
            default: a3d3_ff <= a3d3_ff + (132'(m3_pr) <<< 66);
         endcase
      end
      if (cmd.sum) begin
         pos_ff <= (ACC_W'(a0) <<< POS_SH) + (ACC_W'(a1d_ff) <<< VEL_SH)
                 + (ACC_W'(a2d2_ff) <<< FRAC_BITS) + ACC_W'(a3d3_ff);
         vel_ff <= (ACC_W'(a1) <<< VEL_SH) + ((ACC_W'(a2d_ff) <<< FRAC_BITS) <<< 1)
                 + ACC_W'(a3d2_ff) + (ACC_W'(a3d2_ff) <<< 1);
      end
   end

   // round half up and saturate
   function automatic logic [31:0] round_sat(input logic signed [ACC_W-1:0] a,
                                              input int sh);
      logic signed [ACC_W-1:0] r;
      logic signed [ACC_W-1:0] hi_lim, lo_lim;
      begin
         r      = (a + (ACC_W'(1) <<< (sh - 1))) >>> sh;
         hi_lim = ACC_W'(32'sh7FFF_FFFF);
         lo_lim = -(ACC_W'(33'sh0_8000_0000));
         if (r > hi_lim) begin
            round_sat = 32'h7FFF_FFFF;
         end else if (r < lo_lim) begin
            round_sat = 32'h8000_0000;
         end else begin
            round_sat = r[31:0];
         end
      end
   endfunction

   // result register
   always_ff @(posedge clock) begin
      rsp_valid <= cmd.emit || cmd.error;
      if (cmd.error) begin
         rsp <= '{joint_number: '0, position: '0, velocity: '0,
                  status: 1'b1, last_of_run: 1'b1};
      end else begin
         rsp.joint_number <= JNT_IDX_W'(jnt_sel);
         rsp.position     <= round_sat(pos_ff, POS_SH);
         rsp.velocity     <= round_sat(vel_ff, VEL_SH);
         rsp.status       <= 1'b0;
         rsp.last_of_run  <= cmd.last;
      end
   end

endmodule

// ===== hdl/piecewise_cubic_trajectory_eval.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_trajectory_eval
// Multi-joint cubic spline evaluator, top level.
// ----------------------------------------------------------------------------
// A request is taken when start is high while idle and captured at once. A load
// request then keeps busy high for its load step. A query keeps busy high for
// an end-time memory read and a compare per searched segment, then per joint in
// use for a coefficient read, the first product level, the second level and the
// cubic product one 33-bit slice at a time, a sum and an emit; the searched
// segments and the joints in use set its length. An empty table gives its single
// error result without a search, an unmatched one after the search. Each result
// appears the cycle after its emit step, one per strobe on rsp_valid, and cannot
// be stalled.
module piecewise_cubic_trajectory_eval import pcte_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int MAX_JOINTS   = MAX_JOINTS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   logic [SEG_CNT_W-1:0] seg_count_ff;
   logic [JNT_CNT_W-1:0] jnt_count_ff;
   cmd_type              cmd;
   sts_type              sts;
   logic [SW-1:0]        seg_sel;
   logic [JW-1:0]        jnt_sel;
   logic                 rsp_valid_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         jnt_count_ff <= JNT_CNT_W'(8);
      end else if (csr_valid) begin
         if (csr_index == CSR_SEGMENTS) begin
            seg_count_ff <= csr_wdata[SEG_CNT_W-1:0];
         end else begin
            jnt_count_ff <= csr_wdata[JNT_CNT_W-1:0];
         end
      end
   end

   pcte_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_JOINTS(MAX_JOINTS)) u_ctrl (
      .clock, .reset, .start, .mode(req_data.mode),
      .seg_count(seg_count_ff), .jnt_count(jnt_count_ff),
      .sts, .busy, .cmd, .seg_sel, .jnt_sel
   );

   pcte_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_JOINTS(MAX_JOINTS),
             .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .req(req_data), .seg_count(seg_count_ff), .cmd,
      .seg_sel, .jnt_sel, .sts, .rsp_valid(rsp_valid_ff), .rsp(rsp_data)
   );

   // strobe qualified by reset
   always_comb begin
      rsp_valid = rsp_valid_ff && !reset;
   end

   // a request is never taken while busy
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.clamp || cmd.do_load) |-> !busy)
      else $error("command issued while busy");

   // emit and error never coincide
   a_emit_err: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && cmd.error))
      else $error("emit and error together");

   // a result strobe follows an emit or error step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.error) |=> rsp_valid_ff)
      else $error("missing result strobe");

endmodule
